FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pfdr_pkg.sv
package pfdr_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OFF   = 2'd0,
		ST_RUN   = 2'd1,
		ST_FAULT = 2'd2
	} pump_st_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_STARTED   = 4'd1,
		EV_ALREADY   = 4'd2,
		EV_REFUSED   = 4'd3,
		EV_BLOCKED   = 4'd4,
		EV_STOPPED   = 4'd5,
		EV_STOP_FULL = 4'd6,
		EV_MAX_RUN   = 4'd7,
		EV_DRY_RUN   = 4'd8
	} event_t;

	typedef enum logic [1:0] {
		CFG_AUTO_MODE       = 2'd0,
		CFG_MAX_RUN         = 2'd1,
		CFG_CHECK_INTERVAL  = 2'd2,
		CFG_DRY_RUN_TIMEOUT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       tank_full;
		logic       tank_empty;
	} in_item_t;

	typedef struct packed {
		logic        pump_on;
		logic [1:0]  pump_mode_state;
		logic [3:0]  event_res;
		logic        start_ok;
		logic [31:0] run_elapsed_ms;
	} out_item_t;

	typedef struct packed {
		logic        auto_mode;
		logic [31:0] max_run_ms;
		logic [31:0] check_interval_ms;
		logic [31:0] dry_run_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		pump_st_t    status;
		logic [31:0] started_at;
		logic [31:0] last_check;
	} pump_state_t;

endpackage

FILE: hw/rtl/pump_fill_dry_run_controller.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (pfdr_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data  (pfdr_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out is not stalled. An accepted transaction is held in the
// input register; the single-pass step logic then loads the result register, which drives
// out_data. Controller state advances with that move, in order.
// arst_n clears pump state, configuration and both valid flags; no clearing pass.
// A stall on out holds both registers; in_ready stays high while the input register is
// empty or draining that cycle.
`include "assert_macros.svh"

module pump_fill_dry_run_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pfdr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pfdr_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	pfdr_pkg::cfg_t        cfg;
	pfdr_pkg::pump_state_t state_q;
	pfdr_pkg::pump_state_t state_d;
	pfdr_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	pfdr_pkg::out_item_t   result;
	pfdr_pkg::out_item_t   out_q;
	logic                  out_valid_q;
	logic                  s1_fire;
	logic                  in_fire;
	logic                  out_is_run;
	logic                  out_off;
	logic                  out_ok_event;

	// Accept configuration at any time; the host must write only while nothing is in flight (not enforced here).
	assign cfg_ready = 1'b1;

	pfdr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Advance the input register whenever the result register is free or draining.
	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	pfdr_step u_step (
		.cfg     (cfg),
		.state_q (state_q),
		.item    (item_s1),
		.state_d (state_d),
		.result  (result)
	);

	// Hold the accepted transaction in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// Commit controller state only as the item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.now_ms     <= '0;
			state_q.status     <= pfdr_pkg::ST_OFF;
			state_q.started_at <= '0;
			state_q.last_check <= '0;
		end else if (s1_fire) begin
			state_q <= state_d;
		end
	end

	// Result register: load on advance, drop once the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign out_is_run   = (out_q.pump_mode_state == pfdr_pkg::ST_RUN);
	assign out_off      = out_valid_q && !out_q.pump_on;
	assign out_ok_event = (out_q.event_res == pfdr_pkg::EV_STARTED) ||
		(out_q.event_res == pfdr_pkg::EV_ALREADY);

	`ASSERT_NEXT(a_adv_loads_out, clk, arst_n, s1_fire, out_valid_q)
	`ASSERT_IMPLIES(a_drive_matches_state, clk, arst_n, out_valid_q, out_q.pump_on == out_is_run)
	`ASSERT_IMPLIES(a_elapsed_zero_when_idle, clk, arst_n, out_off, out_q.run_elapsed_ms == '0)
	`ASSERT_IMPLIES(a_start_ok_event, clk, arst_n, out_valid_q && out_q.start_ok, out_ok_event)

endmodule

FILE: hw/rtl/pfdr_cfg.sv
module pfdr_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [31:0]         wr_data,
	output pfdr_pkg::cfg_t      cfg
);

	pfdr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (pfdr_pkg::cfg_idx_t'(wr_index))
				pfdr_pkg::CFG_AUTO_MODE: begin
					cfg_q.auto_mode <= wr_data[0];
				end
				pfdr_pkg::CFG_MAX_RUN: begin
					cfg_q.max_run_ms <= wr_data;
				end
				pfdr_pkg::CFG_CHECK_INTERVAL: begin
					cfg_q.check_interval_ms <= wr_data;
				end
				pfdr_pkg::CFG_DRY_RUN_TIMEOUT: begin
					cfg_q.dry_run_timeout_ms <= wr_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/pfdr_step.sv
module pfdr_step (
	input  pfdr_pkg::cfg_t        cfg,
	input  pfdr_pkg::pump_state_t state_q,
	input  pfdr_pkg::in_item_t    item,
	output pfdr_pkg::pump_state_t state_d,
	output pfdr_pkg::out_item_t   result
);

	logic [31:0]       now_nx;
	logic [31:0]       elapsed;
	logic [31:0]       since_check;
	logic              is_tick;
	logic              due;
	logic              began;
	logic              ok;
	logic              running;
	pfdr_pkg::event_t  ev;

	assign is_tick     = (item.cmd == pfdr_pkg::CMD_TICK);
	assign now_nx      = state_q.now_ms + {31'd0, is_tick};
	assign elapsed     = now_nx - state_q.started_at;
	assign since_check = now_nx - state_q.last_check;
	assign due         = cfg.auto_mode && (since_check >= cfg.check_interval_ms);

	always_comb begin
		state_d = state_q;
		ev      = pfdr_pkg::EV_NONE;
		ok      = 1'b0;
		began   = 1'b0;
		unique case (item.cmd)
			pfdr_pkg::CMD_TICK: begin
				state_d.now_ms = now_nx;
				if (due) begin
					state_d.last_check = now_nx;
					if (state_q.status == pfdr_pkg::ST_RUN) begin
						if (item.tank_full) begin
							state_d.status = pfdr_pkg::ST_OFF;
							ev             = pfdr_pkg::EV_STOP_FULL;
						end else if (item.tank_empty && (cfg.dry_run_timeout_ms != '0) &&
							(elapsed >= cfg.dry_run_timeout_ms)) begin
							state_d.status = pfdr_pkg::ST_FAULT;
							ev             = pfdr_pkg::EV_DRY_RUN;
						end
					end else if (state_q.status == pfdr_pkg::ST_OFF) begin
						if (item.tank_empty && !item.tank_full) begin
							state_d.status     = pfdr_pkg::ST_RUN;
							state_d.started_at = now_nx;
							began              = 1'b1;
							ev                 = pfdr_pkg::EV_STARTED;
						end
					end
				end
				// Cutoff applies in every mode; a fresh start has zero run time.
				if ((state_d.status == pfdr_pkg::ST_RUN) && !began &&
					(cfg.max_run_ms != '0) && (elapsed >= cfg.max_run_ms)) begin
					state_d.status = pfdr_pkg::ST_OFF;
					ev             = pfdr_pkg::EV_MAX_RUN;
				end
			end
			pfdr_pkg::CMD_START: begin
				if (state_q.status == pfdr_pkg::ST_RUN) begin
					ev = pfdr_pkg::EV_ALREADY;
					ok = 1'b1;
				end else if (state_q.status == pfdr_pkg::ST_FAULT) begin
					ev = pfdr_pkg::EV_REFUSED;
				end else if (cfg.auto_mode && item.tank_full) begin
					ev = pfdr_pkg::EV_BLOCKED;
				end else begin
					state_d.status     = pfdr_pkg::ST_RUN;
					state_d.started_at = state_q.now_ms;
					began              = 1'b1;
					ev                 = pfdr_pkg::EV_STARTED;
					ok                 = 1'b1;
				end
			end
			pfdr_pkg::CMD_STOP: begin
				if (state_q.status != pfdr_pkg::ST_OFF) begin
					state_d.status = pfdr_pkg::ST_OFF;
					ev             = pfdr_pkg::EV_STOPPED;
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	assign running = (state_d.status == pfdr_pkg::ST_RUN);

	always_comb begin
		result.pump_on         = running;
		result.pump_mode_state = state_d.status;
		result.event_res       = ev;
		result.start_ok        = ok;
		result.run_elapsed_ms  = (running && !began) ? elapsed : '0;
	end

endmodule
